>>> hw/rtl/mbrpeg_pkg.sv
// ----------------------------------------------------------------------------
// MBR partition entry generator package
// Shared widths, codes, microcode word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package mbrpeg_pkg;

	localparam int MAX_ENTRIES = 4;
	localparam int LBA_W       = 32;
	localparam int DVS_W       = 14;
	localparam int SHORT_STEPS = 14;
	localparam int CNT_W       = 6;
	localparam int PC_W        = 4;

	localparam logic [7:0] BOOT_FLAG = 8'h80;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_SIZE  = 2'd1,
		ST_TABLE_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_HEAD_COUNT        = 2'd0,
		REG_SECTORS_PER_TRACK = 2'd1,
		REG_ACTIVE_PARTITION  = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ENDX,
		OP_DIV_ENDX,
		OP_NXT,
		OP_DIV_START,
		OP_DIV_REM,
		OP_CHS_START,
		OP_DIV_LAST,
		OP_CHS_END,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_IN,
		COND_DIV,
		COND_ERR,
		COND_OUT
	} ucond_t;

	typedef struct packed {
		uop_t              op;
		ucond_t            cond;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic div_idle;
		logic err;
		logic out_free;
	} seq_stat_t;

	localparam logic [PC_W-1:0] PC_LOAD = 4'd0;
	localparam logic [PC_W-1:0] PC_EMIT = 4'd15;

	// Microcode ROM. Each divide is started in one step and waited on in the next.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		begin
			w = '{op: OP_NOP, cond: COND_NEXT, target: PC_LOAD};
			case (pc)
				4'd0:  w = '{op: OP_LOAD,      cond: COND_IN,   target: PC_LOAD};
				4'd1:  w = '{op: OP_ENDX,      cond: COND_ERR,  target: PC_EMIT};
				4'd2:  w = '{op: OP_DIV_ENDX,  cond: COND_NEXT, target: PC_LOAD};
				4'd3:  w = '{op: OP_NOP,       cond: COND_DIV,  target: PC_LOAD};
				4'd4:  w = '{op: OP_NXT,       cond: COND_NEXT, target: PC_LOAD};
				4'd5:  w = '{op: OP_DIV_START, cond: COND_NEXT, target: PC_LOAD};
				4'd6:  w = '{op: OP_NOP,       cond: COND_DIV,  target: PC_LOAD};
				4'd7:  w = '{op: OP_DIV_REM,   cond: COND_NEXT, target: PC_LOAD};
				4'd8:  w = '{op: OP_NOP,       cond: COND_DIV,  target: PC_LOAD};
				4'd9:  w = '{op: OP_CHS_START, cond: COND_NEXT, target: PC_LOAD};
				4'd10: w = '{op: OP_DIV_LAST,  cond: COND_NEXT, target: PC_LOAD};
				4'd11: w = '{op: OP_NOP,       cond: COND_DIV,  target: PC_LOAD};
				4'd12: w = '{op: OP_DIV_REM,   cond: COND_NEXT, target: PC_LOAD};
				4'd13: w = '{op: OP_NOP,       cond: COND_DIV,  target: PC_LOAD};
				4'd14: w = '{op: OP_CHS_END,   cond: COND_NEXT, target: PC_LOAD};
				4'd15: w = '{op: OP_EMIT,      cond: COND_OUT,  target: PC_LOAD};
				default: w = '{op: OP_NOP,     cond: COND_ERR,  target: PC_LOAD};
			endcase
			return w;
		end
	endfunction

endpackage

>>> hw/rtl/mbrpeg_div.sv
// ----------------------------------------------------------------------------
// MBR partition entry generator divider
// Restoring divider, one quotient bit per cycle. A full divide produces 32
// quotient bits; a short divide uses only the low 14 dividend bits and produces 14.
// ----------------------------------------------------------------------------
module mbrpeg_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             full,
	input  logic [mbrpeg_pkg::LBA_W-1:0]     dividend,
	input  logic [mbrpeg_pkg::DVS_W-1:0]     divisor,
	output logic [mbrpeg_pkg::LBA_W-1:0]     quotient,
	output logic [mbrpeg_pkg::DVS_W-1:0]     remainder,
	output logic                             busy
);

	logic [mbrpeg_pkg::CNT_W-1:0] cnt_q;
	logic [mbrpeg_pkg::LBA_W-1:0] quot_q;
	logic [mbrpeg_pkg::DVS_W-1:0] rem_q;
	logic [mbrpeg_pkg::DVS_W-1:0] dvs_q;
	logic [mbrpeg_pkg::DVS_W:0]   trial;
	logic                         ge;

	assign busy  = (cnt_q != '0);
	assign trial = {rem_q, quot_q[mbrpeg_pkg::LBA_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= full ? mbrpeg_pkg::CNT_W'(mbrpeg_pkg::LBA_W)
			              : mbrpeg_pkg::CNT_W'(mbrpeg_pkg::SHORT_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The dividend shifts out of the top of quot_q while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			if (full) begin
				quot_q <= dividend;
			end else begin
				quot_q <= {dividend[mbrpeg_pkg::SHORT_STEPS-1:0],
				           {(mbrpeg_pkg::LBA_W-mbrpeg_pkg::SHORT_STEPS){1'b0}}};
			end
		end else if (busy) begin
			rem_q  <= ge ? mbrpeg_pkg::DVS_W'(trial - {1'b0, dvs_q})
			             : trial[mbrpeg_pkg::DVS_W-1:0];
			quot_q <= {quot_q[mbrpeg_pkg::LBA_W-2:0], ge};
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("divider did not start");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> ($stable(quot_q) && $stable(rem_q)))
		else $error("divider result changed while idle");
`endif

endmodule

>>> hw/rtl/mbrpeg_seq.sv
// ----------------------------------------------------------------------------
// MBR partition entry generator sequencer
// Step counter over the microcode ROM with wait and jump conditions.
// ----------------------------------------------------------------------------
module mbrpeg_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbrpeg_pkg::seq_stat_t stat,
	output mbrpeg_pkg::uword_t    uword
);

	logic [mbrpeg_pkg::PC_W-1:0] pc_q;
	logic [mbrpeg_pkg::PC_W-1:0] pc_next;
	logic [mbrpeg_pkg::PC_W-1:0] pc_inc;

	assign uword  = mbrpeg_pkg::ucode(pc_q);
	assign pc_inc = pc_q + 1'b1;

	always_comb begin
		pc_next = pc_q;
		case (uword.cond)
			mbrpeg_pkg::COND_NEXT: pc_next = pc_inc;
			mbrpeg_pkg::COND_IN:   pc_next = stat.in_fire ? pc_inc : pc_q;
			mbrpeg_pkg::COND_DIV:  pc_next = stat.div_idle ? pc_inc : pc_q;
			mbrpeg_pkg::COND_ERR:  pc_next = stat.err ? uword.target : pc_inc;
			mbrpeg_pkg::COND_OUT:  pc_next = stat.out_free ? uword.target : pc_q;
			default:               pc_next = mbrpeg_pkg::PC_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mbrpeg_pkg::PC_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> hw/rtl/mbr_partition_entry_generator_top.sv
// ----------------------------------------------------------------------------
// MBR partition entry generator
// A valid request runs five serial divides on the shared one-bit-per-cycle
// divider before its entry is given; a rejected request (zero size or full
// table) skips them and gives its error result without any divide. After
// either result the next request can be taken in the following cycle. One
// request is in work at a time; the next is taken while a result still waits
// at the output. Reset restores the default geometry and clears the free
// sector and entry index at once.
// ----------------------------------------------------------------------------
module mbr_partition_entry_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic [30:0] size_kib,
	input  logic [7:0]  part_type,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [1:0]  entry_number,
	output logic [7:0]  boot_flag,
	output logic [7:0]  type_out,
	output logic [7:0]  start_head,
	output logic [7:0]  start_sector_byte,
	output logic [7:0]  start_cylinder_low,
	output logic [7:0]  end_head,
	output logic [7:0]  end_sector_byte,
	output logic [7:0]  end_cylinder_low,
	output logic [31:0] lba_start,
	output logic [31:0] lba_length
);

	mbrpeg_pkg::uword_t    uword;
	mbrpeg_pkg::seq_stat_t stat;
	mbrpeg_pkg::status_t   status_q;

	logic [7:0]  head_count_q;
	logic [5:0]  spt_q;
	logic [2:0]  active_q;
	logic [31:0] nfs_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;

	logic [30:0] size_q;
	logic [7:0]  type_q;
	logic [13:0] cyl_q;
	logic [31:0] start_q;
	logic [31:0] work_q;
	logic [31:0] nxt_q;
	logic [9:0]  c_q;
	logic [7:0]  s_head_q, s_sec_q, s_cyl_q;
	logic [7:0]  e_head_q, e_sec_q, e_cyl_q;

	logic [1:0]  o_status_q, o_entry_q;
	logic [7:0]  o_boot_q, o_type_q;
	logic [7:0]  o_s_head_q, o_s_sec_q, o_s_cyl_q;
	logic [7:0]  o_e_head_q, o_e_sec_q, o_e_cyl_q;
	logic [31:0] o_start_q, o_len_q;

	logic [7:0]  hc_eff;
	logic [5:0]  spt_eff;
	logic [13:0] cyl_prod;
	logic [31:0] eff_nfs;
	logic [2:0]  eff_idx;
	logic        in_fire, emit_fire, out_free, err;
	logic        status_ok;

	logic        div_start, div_full, div_busy;
	logic [31:0] div_dividend, div_quot;
	logic [13:0] div_divisor, div_rem;
	logic [7:0]  sec_byte;

	assign hc_eff   = (head_count_q == 8'd0) ? 8'd1 : head_count_q;
	assign spt_eff  = (spt_q == 6'd0) ? 6'd1 : spt_q;
	assign cyl_prod = {6'd0, hc_eff} * {8'd0, spt_eff};
	assign eff_nfs  = restart ? 32'd0 : nfs_q;
	assign eff_idx  = restart ? 3'd0 : idx_q;

	assign in_ready  = (uword.op == mbrpeg_pkg::OP_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (uword.op == mbrpeg_pkg::OP_EMIT) && out_free;
	assign err       = (status_q != mbrpeg_pkg::ST_OK);
	assign status_ok = !err;

	assign stat.in_fire  = in_fire;
	assign stat.div_idle = !div_busy;
	assign stat.err      = err;
	assign stat.out_free = out_free;

	mbrpeg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uword  (uword)
	);

	always_comb begin
		div_start    = 1'b0;
		div_full     = 1'b1;
		div_dividend = work_q;
		div_divisor  = cyl_q;
		case (uword.op)
			mbrpeg_pkg::OP_DIV_ENDX: begin
				div_start = 1'b1;
			end
			mbrpeg_pkg::OP_DIV_START: begin
				div_start    = 1'b1;
				div_dividend = start_q;
			end
			mbrpeg_pkg::OP_DIV_LAST: begin
				div_start    = 1'b1;
				div_dividend = nxt_q - 32'd1;
			end
			mbrpeg_pkg::OP_DIV_REM: begin
				// Remainder within the cylinder splits into head and sector.
				div_start    = 1'b1;
				div_full     = 1'b0;
				div_dividend = {18'd0, div_rem};
				div_divisor  = {8'd0, spt_eff};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mbrpeg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.full      (div_full),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.remainder (div_rem),
		.busy      (div_busy)
	);

	// Sector is one-based; cylinder bits 9..8 ride in the top two bits.
	assign sec_byte = {c_q[9:8], div_rem[5:0] + 6'd1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= 8'd255;
			spt_q        <= 6'd63;
			active_q     <= 3'd1;
			nfs_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= mbrpeg_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				case (mbrpeg_pkg::reg_index_t'(cfg_index))
					mbrpeg_pkg::REG_HEAD_COUNT:        head_count_q <= cfg_data;
					mbrpeg_pkg::REG_SECTORS_PER_TRACK: spt_q        <= cfg_data[5:0];
					mbrpeg_pkg::REG_ACTIVE_PARTITION:  active_q     <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				nfs_q <= eff_nfs;
				idx_q <= eff_idx;
				if (eff_idx >= 3'(mbrpeg_pkg::MAX_ENTRIES)) begin
					status_q <= mbrpeg_pkg::ST_TABLE_FULL;
				end else if (size_kib == 31'd0) begin
					status_q <= mbrpeg_pkg::ST_ZERO_SIZE;
				end else begin
					status_q <= mbrpeg_pkg::ST_OK;
				end
			end else if (emit_fire && status_ok) begin
				nfs_q <= nxt_q;
				idx_q <= idx_q + 3'd1;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uword.op)
			mbrpeg_pkg::OP_LOAD: begin
				if (in_fire) begin
					size_q  <= size_kib;
					type_q  <= part_type;
					cyl_q   <= cyl_prod;
					start_q <= eff_nfs + {26'd0, spt_eff};
				end
			end
			mbrpeg_pkg::OP_ENDX: begin
				work_q <= start_q + {size_q, 1'b0};
			end
			mbrpeg_pkg::OP_NXT: begin
				nxt_q <= work_q + {18'd0, cyl_q} - {18'd0, div_rem};
			end
			mbrpeg_pkg::OP_DIV_REM: begin
				c_q <= div_quot[9:0];
			end
			mbrpeg_pkg::OP_CHS_START: begin
				s_head_q <= div_quot[7:0];
				s_sec_q  <= sec_byte;
				s_cyl_q  <= c_q[7:0];
			end
			mbrpeg_pkg::OP_CHS_END: begin
				e_head_q <= div_quot[7:0];
				e_sec_q  <= sec_byte;
				e_cyl_q  <= c_q[7:0];
			end
			mbrpeg_pkg::OP_EMIT: begin
				if (emit_fire) begin
					o_status_q <= status_q;
					if (status_ok) begin
						o_entry_q  <= idx_q[1:0];
						o_boot_q   <= ({1'b0, idx_q} + 4'd1 == {1'b0, active_q})
						              ? mbrpeg_pkg::BOOT_FLAG : 8'd0;
						o_type_q   <= type_q;
						o_s_head_q <= s_head_q;
						o_s_sec_q  <= s_sec_q;
						o_s_cyl_q  <= s_cyl_q;
						o_e_head_q <= e_head_q;
						o_e_sec_q  <= e_sec_q;
						o_e_cyl_q  <= e_cyl_q;
						o_start_q  <= start_q;
						o_len_q    <= nxt_q - start_q;
					end else begin
						o_entry_q  <= '0;
						o_boot_q   <= '0;
						o_type_q   <= '0;
						o_s_head_q <= '0;
						o_s_sec_q  <= '0;
						o_s_cyl_q  <= '0;
						o_e_head_q <= '0;
						o_e_sec_q  <= '0;
						o_e_cyl_q  <= '0;
						o_start_q  <= '0;
						o_len_q    <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid          = out_valid_q;
	assign status             = o_status_q;
	assign entry_number       = o_entry_q;
	assign boot_flag          = o_boot_q;
	assign type_out           = o_type_q;
	assign start_head         = o_s_head_q;
	assign start_sector_byte  = o_s_sec_q;
	assign start_cylinder_low = o_s_cyl_q;
	assign end_head           = o_e_head_q;
	assign end_sector_byte    = o_e_sec_q;
	assign end_cylinder_low   = o_e_cyl_q;
	assign lba_start          = o_start_q;
	assign lba_length         = o_len_q;

`ifndef SYNTHESIS
	a_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("request taken while the divider is busy");
	a_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && status_ok) |=> (idx_q == $past(idx_q) + 3'd1))
		else $error("entry index did not advance after a good entry");
	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && err) |=> ($stable(nfs_q) && $stable(idx_q)))
		else $error("state changed by a rejected request");
`endif

endmodule
